[rtl/nuop_pkg.sv]
// package for the nmos 6502 undocumented operation unit
// holds opcode codes, status bit positions, register indexes and transaction types
// no dependencies
package nuop_pkg;

	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [7:0] LXA_MAGIC_RST = 8'hFF;
	localparam logic [7:0] XAA_MAGIC_RST = 8'hEE;

	localparam int unsigned FL_C = 0;
	localparam int unsigned FL_Z = 1;
	localparam int unsigned FL_D = 3;
	localparam int unsigned FL_V = 6;
	localparam int unsigned FL_N = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LXA_MAGIC = 1'b0,
		CFG_XAA_MAGIC = 1'b1
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_SLO = 5'd0,
		OP_RLA = 5'd1,
		OP_SRE = 5'd2,
		OP_RRA = 5'd3,
		OP_SAX = 5'd4,
		OP_LXA = 5'd5,
		OP_LAX = 5'd6,
		OP_DCP = 5'd7,
		OP_ISC = 5'd8,
		OP_ANC = 5'd9,
		OP_ALR = 5'd10,
		OP_ARR = 5'd11,
		OP_XAA = 5'd12,
		OP_SBX = 5'd13,
		OP_SHA = 5'd14,
		OP_SHY = 5'd15,
		OP_SHX = 5'd16,
		OP_SHS = 5'd17,
		OP_LAS = 5'd18,
		OP_KIL = 5'd19
	} op_t;

	typedef struct packed {
		logic [4:0]  opcode;
		logic [7:0]  acc_in;
		logic [7:0]  xreg_in;
		logic [7:0]  yreg_in;
		logic [7:0]  sp_in;
		logic [7:0]  status_in;
		logic [7:0]  operand;
		logic [15:0] address;
	} req_item_t;

	typedef struct packed {
		logic [7:0]  acc_out;
		logic [7:0]  xreg_out;
		logic [7:0]  sp_out;
		logic [7:0]  status_out;
		logic        write_enable;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic        halt;
	} rsp_item_t;

	typedef struct packed {
		logic [7:0] lxa_magic;
		logic [7:0] xaa_magic;
	} cfg_t;

endpackage

[rtl/nuop_if.sv]
// channel interfaces for the nmos 6502 undocumented operation unit
// request, result and configuration write channels with valid/ready
// depends on nuop_pkg
interface nuop_req_if;
	import nuop_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nuop_rsp_if;
	import nuop_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nuop_cfg_if;
	import nuop_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/nuop_cfg_regs.sv]
// configuration registers (lxa and xaa magic constants)
// depends on nuop_pkg and nuop_cfg_if
module nuop_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	nuop_cfg_if.sink        cfg,
	output nuop_pkg::cfg_t  cfg_regs
);
	import nuop_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.lxa_magic <= LXA_MAGIC_RST;
			regs_q.xaa_magic <= XAA_MAGIC_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_LXA_MAGIC: regs_q.lxa_magic <= cfg.data;
				CFG_XAA_MAGIC: regs_q.xaa_magic <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/nuop_alu.sv]
// combinational execution logic for one undocumented operation
// computes registers, status, memory write and halt from one request
// depends on nuop_pkg
module nuop_alu (
	input  nuop_pkg::req_item_t req,
	input  nuop_pkg::cfg_t      cfg_regs,
	output nuop_pkg::rsp_item_t rsp
);
	import nuop_pkg::*;

	logic [7:0] a, x, y, s, p, m;
	logic [7:0] addr_hi_p1;
	logic       c_in, d_in;

	// adc operand (rra) and sbc operand (isc)
	logic [7:0] rra_t, isc_t;

	logic       adc_c_in;
	logic [8:0] adc_bin;
	logic [5:0] adc_lo;
	logic [5:0] adc_hi;
	logic [5:0] adc_hi_adj;
	logic [7:0] adc_res;
	logic       adc_c, adc_v, adc_n, adc_z;

	logic       sbc_borrow;
	logic [8:0] sbc_bin;
	logic [7:0] sbc_bin_res;
	logic [4:0] sbc_lo, sbc_lo_adj;
	logic [4:0] sbc_hi, sbc_hi_adj;
	logic [7:0] sbc_res;
	logic       sbc_c, sbc_v;

	logic [7:0] arr_and, arr_r, arr_r1, arr_r2;
	logic [4:0] arr_lo_sum, arr_hi_sum;

	logic [7:0]  dcp_t, dcp_diff, sbx_t, sbx_diff, ax;
	logic [15:0] shy_dst, shx_dst, shs_base;

	assign a = req.acc_in;
	assign x = req.xreg_in;
	assign y = req.yreg_in;
	assign s = req.sp_in;
	assign p = req.status_in;
	assign m = req.operand;
	assign c_in = p[FL_C];
	assign d_in = p[FL_D];
	assign addr_hi_p1 = req.address[15:8] + 8'd1;
	assign ax = a & x;

	assign rra_t = {c_in, m[7:1]};
	assign isc_t = m + 8'd1;
	// rra rotates the operand's low bit into carry before the add
	assign adc_c_in = m[0];

	// add with carry, binary and decimal
	always_comb begin
		adc_bin = {1'b0, a} + {1'b0, rra_t} + {8'd0, adc_c_in};
		adc_lo  = {2'b00, a[3:0]} + {2'b00, rra_t[3:0]} + {5'd0, adc_c_in};
		if (adc_lo > 6'd9) begin
			adc_lo = adc_lo + 6'd6;
		end
		adc_hi = {2'b00, a[7:4]} + {2'b00, rra_t[7:4]} + {5'd0, (adc_lo > 6'd15)};
		adc_hi_adj = (adc_hi > 6'd9) ? (adc_hi + 6'd6) : adc_hi;
		if (d_in) begin
			adc_z   = (adc_bin[7:0] == 8'd0);
			adc_n   = adc_hi[3];
			adc_v   = ~(a[7] ^ rra_t[7]) & (a[7] ^ adc_hi[3]);
			adc_c   = (adc_hi_adj > 6'd15);
			adc_res = {adc_hi_adj[3:0], adc_lo[3:0]};
		end else begin
			adc_z   = (adc_bin[7:0] == 8'd0);
			adc_n   = adc_bin[7];
			adc_v   = ~(a[7] ^ rra_t[7]) & (a[7] ^ adc_bin[7]);
			adc_c   = adc_bin[8];
			adc_res = adc_bin[7:0];
		end
	end

	// subtract with borrow, binary flags and decimal result
	always_comb begin
		sbc_borrow  = ~c_in;
		sbc_bin     = {1'b0, a} - {1'b0, isc_t} - {8'd0, sbc_borrow};
		sbc_bin_res = sbc_bin[7:0];
		sbc_c       = ({1'b0, a} >= ({1'b0, isc_t} + {8'd0, sbc_borrow}));
		sbc_v       = (a[7] ^ isc_t[7]) & (a[7] ^ sbc_bin_res[7]);
		sbc_lo      = {1'b0, a[3:0]} - {1'b0, isc_t[3:0]} - {4'd0, sbc_borrow};
		sbc_lo_adj  = sbc_lo[4] ? (sbc_lo - 5'd6) : sbc_lo;
		sbc_hi      = {1'b0, a[7:4]} - {1'b0, isc_t[7:4]} - {4'd0, sbc_lo_adj[4]};
		sbc_hi_adj  = sbc_hi[4] ? (sbc_hi - 5'd6) : sbc_hi;
		sbc_res     = d_in ? {sbc_hi_adj[3:0], sbc_lo_adj[3:0]} : sbc_bin_res;
	end

	// arr bcd fixups
	always_comb begin
		arr_and    = a & m;
		arr_r      = {c_in, arr_and[7:1]};
		arr_lo_sum = {1'b0, arr_and[3:0]} + {4'd0, arr_and[0]};
		arr_hi_sum = {1'b0, arr_and[7:4]} + {4'd0, arr_and[4]};
		arr_r1     = (arr_lo_sum > 5'd5) ? {arr_r[7:4], arr_r[3:0] + 4'd6} : arr_r;
		arr_r2     = (arr_hi_sum > 5'd5) ? (arr_r1 + 8'h60) : arr_r1;
	end

	assign dcp_t    = m - 8'd1;
	assign dcp_diff = a - dcp_t;
	assign sbx_t    = ax;
	assign sbx_diff = sbx_t - m;
	assign shy_dst  = req.address + {8'd0, x};
	assign shx_dst  = req.address + {8'd0, y};
	assign shs_base = req.address - {8'd0, y};

	always_comb begin
		rsp.acc_out       = a;
		rsp.xreg_out      = x;
		rsp.sp_out        = s;
		rsp.status_out    = p;
		rsp.write_enable  = 1'b0;
		rsp.write_address = 16'd0;
		rsp.write_data    = 8'd0;
		rsp.halt          = 1'b0;
		unique case (op_t'(req.opcode))
			OP_SLO: begin
				rsp.status_out[FL_C] = m[7];
				rsp.write_enable     = 1'b1;
				rsp.write_address    = req.address;
				rsp.write_data       = {m[6:0], 1'b0};
				rsp.acc_out          = a | {m[6:0], 1'b0};
			end
			OP_RLA: begin
				rsp.status_out[FL_C] = m[7];
				rsp.write_enable     = 1'b1;
				rsp.write_address    = req.address;
				rsp.write_data       = {m[6:0], c_in};
				rsp.acc_out          = a & {m[6:0], c_in};
			end
			OP_SRE: begin
				rsp.status_out[FL_C] = m[0];
				rsp.write_enable     = 1'b1;
				rsp.write_address    = req.address;
				rsp.write_data       = {1'b0, m[7:1]};
				rsp.acc_out          = a ^ {1'b0, m[7:1]};
			end
			OP_RRA: begin
				rsp.write_enable     = 1'b1;
				rsp.write_address    = req.address;
				rsp.write_data       = rra_t;
				rsp.acc_out          = adc_res;
				rsp.status_out[FL_C] = adc_c;
				rsp.status_out[FL_V] = adc_v;
				rsp.status_out[FL_N] = adc_n;
				rsp.status_out[FL_Z] = adc_z;
			end
			OP_SAX: begin
				rsp.write_enable  = 1'b1;
				rsp.write_address = req.address;
				rsp.write_data    = ax;
			end
			OP_LXA: begin
				rsp.acc_out  = (a | cfg_regs.lxa_magic) & m;
				rsp.xreg_out = (a | cfg_regs.lxa_magic) & m;
			end
			OP_LAX: begin
				rsp.acc_out  = m;
				rsp.xreg_out = m;
			end
			OP_DCP: begin
				rsp.write_enable     = 1'b1;
				rsp.write_address    = req.address;
				rsp.write_data       = dcp_t;
				rsp.status_out[FL_C] = (a >= dcp_t);
				rsp.status_out[FL_N] = dcp_diff[7];
				rsp.status_out[FL_Z] = (dcp_diff == 8'd0);
			end
			OP_ISC: begin
				rsp.write_enable     = 1'b1;
				rsp.write_address    = req.address;
				rsp.write_data       = isc_t;
				rsp.acc_out          = sbc_res;
				rsp.status_out[FL_C] = sbc_c;
				rsp.status_out[FL_V] = sbc_v;
				rsp.status_out[FL_N] = sbc_bin_res[7];
				rsp.status_out[FL_Z] = (sbc_bin_res == 8'd0);
			end
			OP_ANC: begin
				rsp.acc_out          = a & m;
				rsp.status_out[FL_C] = a[7] & m[7];
			end
			OP_ALR: begin
				rsp.acc_out          = {1'b0, arr_and[7:1]};
				rsp.status_out[FL_C] = arr_and[0];
			end
			OP_ARR: begin
				rsp.status_out[FL_N] = arr_r[7];
				rsp.status_out[FL_Z] = (arr_r == 8'd0);
				if (d_in) begin
					rsp.status_out[FL_V] = arr_and[6] ^ arr_r[6];
					rsp.status_out[FL_C] = (arr_hi_sum > 5'd5);
					rsp.acc_out          = arr_r2;
				end else begin
					rsp.status_out[FL_C] = arr_r[6];
					rsp.status_out[FL_V] = arr_r[6] ^ arr_r[5];
					rsp.acc_out          = arr_r;
				end
			end
			OP_XAA: begin
				rsp.acc_out = (a | cfg_regs.xaa_magic) & x & m;
			end
			OP_SBX: begin
				rsp.xreg_out         = sbx_diff;
				rsp.status_out[FL_C] = (sbx_t >= m);
			end
			OP_SHA: begin
				rsp.write_enable  = 1'b1;
				rsp.write_address = req.address;
				rsp.write_data    = ax & addr_hi_p1;
			end
			OP_SHY: begin
				if (shy_dst[15:8] == req.address[15:8]) begin
					rsp.write_enable  = 1'b1;
					rsp.write_address = shy_dst;
					rsp.write_data    = y & addr_hi_p1;
				end
			end
			OP_SHX: begin
				if (shx_dst[15:8] == req.address[15:8]) begin
					rsp.write_enable  = 1'b1;
					rsp.write_address = shx_dst;
					rsp.write_data    = x & addr_hi_p1;
				end
			end
			OP_SHS: begin
				rsp.sp_out        = ax;
				rsp.write_enable  = 1'b1;
				rsp.write_address = req.address;
				rsp.write_data    = ax & (shs_base[15:8] + 8'd1);
			end
			OP_LAS: begin
				rsp.acc_out  = s & m;
				rsp.xreg_out = s & m;
				rsp.sp_out   = s & m;
			end
			OP_KIL: begin
				rsp.halt = 1'b1;
			end
			default: ;
		endcase
		// n and z follow the new accumulator for the logic group and the new x for sbx
		unique case (op_t'(req.opcode))
			OP_SLO, OP_RLA, OP_SRE, OP_LXA, OP_LAX, OP_ANC, OP_ALR, OP_XAA, OP_LAS: begin
				rsp.status_out[FL_N] = rsp.acc_out[7];
				rsp.status_out[FL_Z] = (rsp.acc_out == 8'd0);
			end
			OP_SBX: begin
				rsp.status_out[FL_N] = sbx_diff[7];
				rsp.status_out[FL_Z] = (sbx_diff == 8'd0);
			end
			default: ;
		endcase
	end

endmodule

[rtl/nmos_6502_undocumented_op_unit.sv]
// nmos 6502 undocumented operation unit, top level
// request -> input register -> execution logic -> result register -> result
// channels: request (one instruction per transaction: opcode, a, x, y, s, p,
//   operand byte, address), result (new a, x, s, p, optional memory write,
//   halt) and cfg (writes of lxa_magic at index 0, xaa_magic at index 1)
// every request transaction gives exactly one result transaction, in order
// an accepted request is captured in the input register, and the alu result for it is
//   captured in the result register, which drives the result transaction
// throughput: one transaction per cycle while the receiver takes results; both stages are
//   registers with the byte alu between them
// cfg is always ready; write it only while no transaction is in flight
// reset clears both stage valids and loads lxa_magic 0xff, xaa_magic 0xee
// when the receiver stalls the result register holds, the input stage
//   fills behind it, then request ready drops until the result is taken
// depends on nuop_pkg, nuop_if, nuop_cfg_regs and nuop_alu
module nmos_6502_undocumented_op_unit (
	input  logic        clk,
	input  logic        arst_n,
	nuop_req_if.sink    request,
	nuop_rsp_if.source  result,
	nuop_cfg_if.sink    cfg
);
	import nuop_pkg::*;

	cfg_t      cfg_regs;
	req_item_t req_s1;
	logic      valid_s1;
	rsp_item_t alu_rsp;
	rsp_item_t rsp_s2;
	logic      valid_s2;
	logic      adv_s2;

	nuop_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	nuop_alu u_alu (
		.req      (req_s1),
		.cfg_regs (cfg_regs),
		.rsp      (alu_rsp)
	);

	assign adv_s2        = valid_s1 && (!valid_s2 || result.ready);
	assign request.ready = !valid_s1 || adv_s2;
	assign result.valid  = valid_s2;
	assign result.data   = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (request.ready) begin
				valid_s1 <= request.valid;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			req_s1 <= request.data;
		end
		if (adv_s2) begin
			rsp_s2 <= alu_rsp;
		end
	end

endmodule
